@@ sv/ths_pkg.sv @@
// Shared types, flag codes and connection state codes for the TCP handshake responder.
package ths_pkg;

    // TCP flag bits and the flag combinations that the responder recognizes.
    localparam logic [7:0] FL_FIN     = 8'h01;
    localparam logic [7:0] FL_SYN     = 8'h02;
    localparam logic [7:0] FL_RST     = 8'h04;
    localparam logic [7:0] FL_PSH     = 8'h08;
    localparam logic [7:0] FL_ACK     = 8'h10;
    localparam logic [7:0] FL_SYN_ACK = FL_SYN | FL_ACK;
    localparam logic [7:0] FL_ACK_PSH = FL_ACK | FL_PSH;
    localparam logic [7:0] FL_FIN_ACK = FL_FIN | FL_ACK;

    // Connection state codes as they appear on the reply.
    localparam logic [2:0] ST_CLOSED      = 3'd0;
    localparam logic [2:0] ST_HALF_OPEN   = 3'd1;
    localparam logic [2:0] ST_ESTABLISHED = 3'd2;
    localparam logic [2:0] ST_FIN_SEEN    = 3'd3;
    localparam logic [2:0] ST_FIN_SENT    = 3'd4;

    // Received segment header.
    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] payload_len;
    } seg_t;

    // Reply descriptor.
    typedef struct packed {
        logic        send;
        logic        data_ready;
        logic [47:0] reply_dst_mac;
        logic [47:0] reply_src_mac;
        logic [31:0] reply_dst_ip;
        logic [31:0] reply_src_ip;
        logic [15:0] reply_dst_port;
        logic [15:0] reply_src_port;
        logic [7:0]  reply_flags;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [2:0]  conn_state;
    } reply_t;

    // Segment class decided from the flag byte alone.
    typedef enum logic [2:0] {
        EV_NONE,
        EV_SYN,
        EV_SYN_ACK,
        EV_ACK,
        EV_ACK_PSH,
        EV_FIN_ACK
    } event_t;

    // Classified segment as it travels from the front end to the engine.
    typedef struct packed {
        seg_t        hdr;
        event_t      ev;
        logic [31:0] seq_plus_one;
        logic [31:0] seq_plus_len;
        logic [31:0] ack_minus_one;
    } cls_item_t;

endpackage

@@ sv/ths_classify.sv @@
// Front end: classifies each received segment and precomputes the sequence arithmetic.
module ths_classify (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seg_valid,
    output logic               seg_ready,
    input  ths_pkg::seg_t      seg,
    output logic               cls_valid,
    input  logic               cls_ready,
    output ths_pkg::cls_item_t cls
);

    logic               cls_valid_reg;
    ths_pkg::cls_item_t cls_reg;
    ths_pkg::cls_item_t cls_next;
    ths_pkg::event_t    ev;

    // The flag byte must match a recognized combination exactly.
    always_comb
    begin
        case (seg.seg_flags)
            ths_pkg::FL_SYN:     ev = ths_pkg::EV_SYN;
            ths_pkg::FL_SYN_ACK: ev = ths_pkg::EV_SYN_ACK;
            ths_pkg::FL_ACK:     ev = ths_pkg::EV_ACK;
            ths_pkg::FL_ACK_PSH: ev = ths_pkg::EV_ACK_PSH;
            ths_pkg::FL_FIN_ACK: ev = ths_pkg::EV_FIN_ACK;
            default:             ev = ths_pkg::EV_NONE;
        endcase
    end

    always_comb
    begin
        cls_next.hdr           = seg;
        cls_next.ev            = ev;
        cls_next.seq_plus_one  = seg.seg_seq + 32'd1;
        cls_next.seq_plus_len  = seg.seg_seq + {16'd0, seg.payload_len};
        cls_next.ack_minus_one = seg.seg_ack - 32'd1;
    end

    assign seg_ready = !cls_valid_reg || cls_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (seg_ready)
        begin
            cls_valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_valid && seg_ready)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = cls_valid_reg;
    assign cls       = cls_reg;

endmodule

@@ sv/ths_queue.sv @@
// Two-entry queue that decouples the classifier from the connection engine.
module ths_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  ths_pkg::cls_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output ths_pkg::cls_item_t rd_item
);

    ths_pkg::cls_item_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ sv/ths_engine.sv @@
// Back end: connection state machine that turns classified segments into replies.
module ths_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cls_valid,
    output logic               cls_ready,
    input  ths_pkg::cls_item_t cls,
    output logic               reply_valid,
    input  logic               reply_ready,
    output ths_pkg::reply_t    reply
);

    typedef enum logic [2:0] {
        CLOSED      = ths_pkg::ST_CLOSED,
        HALF_OPEN   = ths_pkg::ST_HALF_OPEN,
        ESTABLISHED = ths_pkg::ST_ESTABLISHED,
        FIN_SEEN    = ths_pkg::ST_FIN_SEEN,
        FIN_SENT    = ths_pkg::ST_FIN_SENT
    } phase_t;

    phase_t          phase_reg;
    phase_t          phase_next;
    logic            client_reg;
    logic            client_next;
    logic [31:0]     sent_seq_reg;
    logic [31:0]     sent_seq_next;
    logic [31:0]     sent_ack_reg;
    logic [31:0]     sent_ack_next;
    logic            reply_valid_reg;
    ths_pkg::reply_t reply_reg;
    ths_pkg::reply_t reply_next;
    logic            take;

    assign take      = cls_valid && (!reply_valid_reg || reply_ready);
    assign cls_ready = take;

    always_comb
    begin
        phase_next    = phase_reg;
        client_next   = client_reg;
        sent_seq_next = sent_seq_reg;
        sent_ack_next = sent_ack_reg;

        reply_next.send           = 1'b0;
        reply_next.data_ready     = 1'b0;
        reply_next.reply_dst_mac  = cls.hdr.src_mac;
        reply_next.reply_src_mac  = cls.hdr.dst_mac;
        reply_next.reply_dst_ip   = cls.hdr.src_ip;
        reply_next.reply_src_ip   = cls.hdr.dst_ip;
        reply_next.reply_dst_port = cls.hdr.src_port;
        reply_next.reply_src_port = cls.hdr.dst_port;
        reply_next.reply_flags    = cls.hdr.seg_flags;
        reply_next.reply_seq      = cls.hdr.seg_seq;
        reply_next.reply_ack      = cls.hdr.seg_ack;

        if (cls.ev == ths_pkg::EV_FIN_ACK)
        begin
            // Teardown is honored in every phase and goes straight to FIN_SENT; FIN_SEEN is never used.
            reply_next.reply_flags = ths_pkg::FL_FIN_ACK;
            reply_next.reply_seq   = cls.hdr.seg_ack;
            reply_next.reply_ack   = cls.seq_plus_one;
            reply_next.send        = 1'b1;
            phase_next             = FIN_SENT;
        end
        else
        begin
            case (phase_reg)
                CLOSED:
                begin
                    if (cls.ev == ths_pkg::EV_SYN || cls.ev == ths_pkg::EV_SYN_ACK)
                    begin
                        reply_next.reply_seq = cls.hdr.seg_ack;
                        reply_next.reply_ack = cls.seq_plus_one;
                        reply_next.send      = 1'b1;
                        sent_seq_next        = cls.hdr.seg_ack;
                        sent_ack_next        = cls.seq_plus_one;
                        if (cls.ev == ths_pkg::EV_SYN)
                        begin
                            reply_next.reply_flags = ths_pkg::FL_SYN_ACK;
                            client_next            = 1'b0;
                            phase_next             = HALF_OPEN;
                        end
                        else
                        begin
                            reply_next.reply_flags = ths_pkg::FL_ACK;
                            client_next            = 1'b1;
                            phase_next             = ESTABLISHED;
                        end
                    end
                end
                HALF_OPEN:
                begin
                    if (cls.ev == ths_pkg::EV_ACK && sent_seq_reg == cls.ack_minus_one
                        && sent_ack_reg == cls.hdr.seg_seq)
                    begin
                        phase_next = ESTABLISHED;
                    end
                end
                ESTABLISHED:
                begin
                    if (cls.ev == ths_pkg::EV_ACK_PSH)
                    begin
                        reply_next.reply_seq  = cls.hdr.seg_ack;
                        reply_next.reply_ack  = cls.seq_plus_len;
                        reply_next.data_ready = 1'b1;
                        if (client_reg)
                        begin
                            reply_next.reply_flags = ths_pkg::FL_ACK;
                            reply_next.send        = 1'b1;
                        end
                    end
                end
                FIN_SENT:
                begin
                    phase_next = CLOSED;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        reply_next.conn_state = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= CLOSED;
            client_reg      <= 1'b0;
            sent_seq_reg    <= 32'd0;
            sent_ack_reg    <= 32'd0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg    <= phase_next;
                client_reg   <= client_next;
                sent_seq_reg <= sent_seq_next;
                sent_ack_reg <= sent_ack_next;
                reply_reg    <= reply_next;
            end
            if (take)
            begin
                reply_valid_reg <= 1'b1;
            end
            else if (reply_ready)
            begin
                reply_valid_reg <= 1'b0;
            end
        end
    end

    assign reply_valid = reply_valid_reg;
    assign reply       = reply_reg;

endmodule

@@ sv/tcp_handshake_responder.sv @@
// Top level of the single-connection TCP handshake responder.
//
//   Channel   Handshake                   Payload             Transfer carries
//   segment   seg_valid / seg_ready       seg   (seg_t)       one received segment header
//   reply     reply_valid / reply_ready   reply (reply_t)     one reply descriptor
//
// Every accepted segment produces exactly one reply, in order.
// Throughput is one segment per clock while reply_ready stays high; the connection engine decides one
// segment per cycle from its state registers and one compare set.
// A transferred segment is registered in the classifier register, then in the
// two-entry queue and then in the engine output register, which drives
// reply_valid.
// rst_n clears the connection to CLOSED with server role and zero recorded
// seq and ack, and empties every stage.
// A stalled reply channel fills the output register, then the queue, then the
// classifier register before seg_ready drops; each side stalls on its own.
//
// The front end classifies the flag byte and precomputes seq+1, seq+length
// and ack-1, so the engine only compares and selects. The engine applies
// FIN|ACK in any state, answers SYN and SYN|ACK in CLOSED, checks the
// handshake ACK against the recorded seq and ack in HALF_OPEN, handles
// ACK|PSH data in ESTABLISHED and returns to CLOSED from FIN_SENT.
// Addresses and ports are always swapped in the reply.
module tcp_handshake_responder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seg_valid,
    output logic            seg_ready,
    input  ths_pkg::seg_t   seg,
    output logic            reply_valid,
    input  logic            reply_ready,
    output ths_pkg::reply_t reply
);

    logic               cls_valid;
    logic               cls_ready;
    ths_pkg::cls_item_t cls;
    logic               q_valid;
    logic               q_ready;
    ths_pkg::cls_item_t q_item;

    ths_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls       (cls)
    );

    ths_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cls_valid),
        .wr_ready (cls_ready),
        .wr_item  (cls),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    ths_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cls_valid   (q_valid),
        .cls_ready   (q_ready),
        .cls         (q_item),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply)
    );

`ifndef SYNTHESIS
    // Delivered payload only happens in the established state.
    a_data_in_established: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply.data_ready |-> reply.conn_state == ths_pkg::ST_ESTABLISHED)
        else $error("data_ready reply outside ESTABLISHED");

    // A reply that lands in FIN_SENT is always the FIN|ACK answer.
    a_fin_sent_reply: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply.conn_state == ths_pkg::ST_FIN_SENT
        |-> reply.send && reply.reply_flags == ths_pkg::FL_FIN_ACK)
        else $error("FIN_SENT reached without FIN|ACK reply");

    // The state on a reply never leaves the defined range.
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |-> reply.conn_state <= ths_pkg::ST_FIN_SENT)
        else $error("reply carries an undefined connection state");

    // A SYN|ACK reply is only sent when entering HALF_OPEN.
    a_syn_ack_state: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply.send && reply.reply_flags == ths_pkg::FL_SYN_ACK
        |-> reply.conn_state == ths_pkg::ST_HALF_OPEN)
        else $error("SYN|ACK reply sent outside passive open");
`endif

endmodule
